>>> rtl/level_strip_packer_best_fit_core_assert.svh
// assertion macros for the shelf packer, empty under synthesis
`ifndef LEVEL_STRIP_PACKER_BEST_FIT_CORE_ASSERT_SVH
`define LEVEL_STRIP_PACKER_BEST_FIT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LSPBF_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("lspbf: same-cycle check failed");
// next-cycle implication
`define LSPBF_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("lspbf: next-cycle check failed");
`else
`define LSPBF_ASSERT_IMP(lbl, a, b)
`define LSPBF_ASSERT_NXT(lbl, a, b)
`endif
`endif

>>> rtl/lspbf_pkg.sv
package lspbf_pkg;

  // field widths
  localparam int unsigned WID_W = 16;
  localparam int unsigned HGT_W = 16;
  localparam int unsigned POS_Y_W = 22;
  localparam int unsigned IDX_OUT_W = 5;

  typedef logic [WID_W-1:0] wid_t;
  typedef logic [HGT_W-1:0] hgt_t;
  typedef logic [POS_Y_W-1:0] ypos_t;
  typedef logic [IDX_OUT_W-1:0] idx_out_t;

  // saturation limit of the packed height
  localparam ypos_t HEIGHT_MAX = 22'h3FFFFF;

  // strip width after reset
  localparam wid_t STRIP_WIDTH_RESET = 16'd1024;

  // request actions
  localparam logic ACT_PLACE = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

endpackage

>>> rtl/lspbf_if.sv
// request channel: one rectangle or a clear
interface lspbf_req_if;
  logic              valid;
  logic              ready;
  logic              action;
  lspbf_pkg::wid_t   rect_width;
  lspbf_pkg::hgt_t   rect_height;

  modport source (output valid, action, rect_width, rect_height, input ready);
  modport sink (input valid, action, rect_width, rect_height, output ready);
endinterface

// result channel: placement of one rectangle
interface lspbf_rsp_if;
  logic                  valid;
  logic                  ready;
  lspbf_pkg::wid_t       pos_x;
  lspbf_pkg::ypos_t      pos_y;
  lspbf_pkg::idx_out_t   shelf_index;
  logic                  opened_shelf;
  lspbf_pkg::ypos_t      packed_height;
  logic                  shelves_full;

  modport source (
    output valid, pos_x, pos_y, shelf_index, opened_shelf, packed_height, shelves_full,
    input ready
  );
  modport sink (
    input valid, pos_x, pos_y, shelf_index, opened_shelf, packed_height, shelves_full,
    output ready
  );
endinterface

>>> rtl/level_strip_packer_best_fit_core.sv
// a placement scans the open shelves in the shelf memory, one shelf per cycle, then updates the
// shelf state and loads the result into the output register; a clear skips the scan
// one request at a time: the next is taken only after the result is loaded into the output
// register, and that load waits while the previous result has not been taken
// reset (rst, synchronous): no shelves open, packed height 0, strip width 1024
module level_strip_packer_best_fit_core #(
  parameter int unsigned MAX_SHELVES = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  lspbf_pkg::wid_t       cfg_data,
  lspbf_req_if.sink             req,
  lspbf_rsp_if.source           rsp
);

  `include "level_strip_packer_best_fit_core_assert.svh"

  localparam int unsigned IDX_W = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_SHELVES + 1);
  localparam int unsigned IDXX_W = (IDX_W > lspbf_pkg::IDX_OUT_W) ? IDX_W :
                                   lspbf_pkg::IDX_OUT_W;
  localparam int unsigned POS_Y_W_L = lspbf_pkg::POS_Y_W + 1;

  // sequencer states
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;
  localparam logic [1:0] ST_OUT    = 2'd3;

  logic [1:0] state;

  // control state
  logic [CNT_W-1:0]   shelf_count;
  lspbf_pkg::ypos_t   total_height;
  lspbf_pkg::wid_t    strip_width;
  logic [CNT_W-1:0]   rd_cnt;
  logic               pend;
  logic               found;
  logic               out_valid;

  // request and scan payload
  logic               act_q;
  lspbf_pkg::wid_t    w_q;
  lspbf_pkg::hgt_t    h_q;
  logic [CNT_W-1:0]   n_q;
  logic [IDX_W-1:0]   cmp_idx;
  lspbf_pkg::wid_t    fill_q;
  lspbf_pkg::ypos_t   base_q;
  logic [IDX_W-1:0]   best_idx;
  lspbf_pkg::wid_t    best_fill;
  lspbf_pkg::ypos_t   best_base;

  // finished result and output register
  lspbf_pkg::wid_t     res_x;
  lspbf_pkg::ypos_t    res_y;
  lspbf_pkg::idx_out_t res_idx;
  logic                res_open;
  lspbf_pkg::ypos_t    res_ph;
  logic                res_full;
  lspbf_pkg::wid_t     out_x;
  lspbf_pkg::ypos_t    out_y;
  lspbf_pkg::idx_out_t out_idx;
  logic                out_open;
  lspbf_pkg::ypos_t    out_ph;
  logic                out_full;

  // shelf memory
  lspbf_pkg::wid_t  shelf_fill [MAX_SHELVES];
  lspbf_pkg::ypos_t shelf_base [MAX_SHELVES];

  // scan compare
  logic fit;
  logic better;
  logic scan_done;
  logic out_load;

  // update decisions
  logic                 is_full;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_wa;
  lspbf_pkg::wid_t      mem_wfill;
  logic [POS_Y_W_L-1:0] top_sum;
  lspbf_pkg::ypos_t     top_sat;
  logic [IDX_W-1:0]     idx_sel;
  logic [IDXX_W-1:0]    idx_wide;
  logic                 req_take;

  assign req.ready = (state == ST_IDLE);
  assign req_take  = req.valid && req.ready;

  // fit test and best-so-far compare on the shelf just read
  assign fit = (fill_q <= strip_width) && ((strip_width - fill_q) >= w_q);
  assign better = !found || (fill_q > best_fill);
  assign scan_done = (rd_cnt == n_q) && !pend;
  assign out_load = !out_valid || rsp.ready;

  // choose what the update writes
  assign is_full   = (n_q == CNT_W'(MAX_SHELVES));
  assign top_sum   = {1'b0, total_height} + POS_Y_W_L'(h_q);
  assign top_sat   = (top_sum > POS_Y_W_L'(lspbf_pkg::HEIGHT_MAX)) ? lspbf_pkg::HEIGHT_MAX :
                     top_sum[lspbf_pkg::POS_Y_W-1:0];
  assign mem_we    = (state == ST_UPDATE) && !act_q && (found || !is_full);
  assign mem_wa    = found ? best_idx : n_q[IDX_W-1:0];
  assign mem_wfill = found ? (best_fill + w_q) : w_q;
  assign idx_sel   = found ? best_idx : n_q[IDX_W-1:0];
  assign idx_wide  = IDXX_W'(idx_sel);

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      shelf_fill[mem_wa] <= mem_wfill;
      if (!found) begin
        shelf_base[mem_wa] <= total_height;
      end
    end
    fill_q <= shelf_fill[rd_cnt[IDX_W-1:0]];
    base_q <= shelf_base[rd_cnt[IDX_W-1:0]];
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      shelf_count  <= '0;
      total_height <= '0;
      strip_width  <= lspbf_pkg::STRIP_WIDTH_RESET;
      rd_cnt       <= '0;
      pend         <= 1'b0;
      found        <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        strip_width <= cfg_data;
      end
      // output valid: set on load, cleared when taken
      if (state == ST_OUT && out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_take) begin
            rd_cnt <= '0;
            pend   <= 1'b0;
            found  <= 1'b0;
            state  <= (req.action == lspbf_pkg::ACT_CLEAR) ? ST_UPDATE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_cnt != n_q) begin
            rd_cnt <= rd_cnt + CNT_W'(1);
            pend   <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend && fit && better) begin
            found <= 1'b1;
          end
          if (scan_done) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (act_q == lspbf_pkg::ACT_CLEAR) begin
            shelf_count  <= '0;
            total_height <= '0;
          end else if (!found && !is_full) begin
            shelf_count  <= n_q + CNT_W'(1);
            total_height <= top_sat;
          end
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // capture request
    if (req_take) begin
      act_q <= req.action;
      w_q   <= req.rect_width;
      h_q   <= req.rect_height;
      n_q   <= shelf_count;
    end
    // scan pipeline index and best candidate
    if (state == ST_SCAN) begin
      cmp_idx <= rd_cnt[IDX_W-1:0];
      if (pend && fit && better) begin
        best_idx  <= cmp_idx;
        best_fill <= fill_q;
        best_base <= base_q;
      end
    end
    // result of this request
    if (state == ST_UPDATE) begin
      if (act_q == lspbf_pkg::ACT_CLEAR) begin
        res_x    <= '0;
        res_y    <= '0;
        res_idx  <= '0;
        res_open <= 1'b0;
        res_ph   <= '0;
        res_full <= 1'b0;
      end else if (found) begin
        res_x    <= best_fill;
        res_y    <= best_base;
        res_idx  <= idx_wide[lspbf_pkg::IDX_OUT_W-1:0];
        res_open <= 1'b0;
        res_ph   <= total_height;
        res_full <= 1'b0;
      end else if (is_full) begin
        res_x    <= '0;
        res_y    <= '0;
        res_idx  <= '0;
        res_open <= 1'b0;
        res_ph   <= total_height;
        res_full <= 1'b1;
      end else begin
        res_x    <= '0;
        res_y    <= total_height;
        res_idx  <= idx_wide[lspbf_pkg::IDX_OUT_W-1:0];
        res_open <= 1'b1;
        res_ph   <= top_sat;
        res_full <= 1'b0;
      end
    end
    // output register
    if (state == ST_OUT && out_load) begin
      out_x    <= res_x;
      out_y    <= res_y;
      out_idx  <= res_idx;
      out_open <= res_open;
      out_ph   <= res_ph;
      out_full <= res_full;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.pos_x         = out_x;
  assign rsp.pos_y         = out_y;
  assign rsp.shelf_index   = out_idx;
  assign rsp.opened_shelf  = out_open;
  assign rsp.packed_height = out_ph;
  assign rsp.shelves_full  = out_full;

  // checks
  `LSPBF_ASSERT_IMP(a_count_bound, 1'b1, shelf_count <= CNT_W'(MAX_SHELVES))
  `LSPBF_ASSERT_IMP(a_scan_bound, state == ST_SCAN, rd_cnt <= n_q)
  `LSPBF_ASSERT_IMP(a_open_xor_full, out_valid, !(out_open && out_full))
  `LSPBF_ASSERT_NXT(a_height_grows, state == ST_UPDATE && act_q == lspbf_pkg::ACT_PLACE,
                    total_height >= $past(total_height))

endmodule

>>> sim/tb_level_strip_packer_best_fit_core.sv
`timescale 1ns / 100ps

module tb_level_strip_packer_best_fit_core;

  localparam int SHELF_LIMIT = 32;
  localparam int RAND_RECTS = 1650;

  typedef struct {
    bit              is_cfg;
    lspbf_pkg::wid_t cfg_val;
    logic            action;
    lspbf_pkg::wid_t w;
    lspbf_pkg::hgt_t h;
  } rect_req_t;

  typedef struct {
    lspbf_pkg::wid_t     pos_x;
    lspbf_pkg::ypos_t    pos_y;
    lspbf_pkg::idx_out_t shelf_index;
    logic                opened_shelf;
    lspbf_pkg::ypos_t    packed_height;
    logic                shelves_full;
  } placement_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  lspbf_pkg::wid_t cfg_data;

  lspbf_req_if req_ch ();
  lspbf_rsp_if rsp_ch ();

  level_strip_packer_best_fit_core #(.MAX_SHELVES(SHELF_LIMIT)) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  rect_req_t  request_q[$];
  placement_t placement_q[$];

  // shelf state mirrored by the predictor
  lspbf_pkg::wid_t  cur_width = lspbf_pkg::STRIP_WIDTH_RESET;
  lspbf_pkg::wid_t  fill_of [SHELF_LIMIT];
  lspbf_pkg::ypos_t base_of [SHELF_LIMIT];
  int               open_shelves = 0;
  lspbf_pkg::ypos_t stack_top = '0;

  int errors = 0;
  int sent = 0;
  int seen = 0;
  int clears = 0;
  int opened = 0;
  int dropped = 0;
  int cfg_writes = 0;
  int queued_rects = 0;
  int quiet_cycles = 0;
  int cyc = 0;
  logic steady;

  always #10 clk = ~clk;

  // free-running cycle count, with a stretch of no idling in every window
  always @(posedge clk) begin
    cyc <= cyc + 1;
  end
  assign steady = (cyc % 6000) >= 4800;

  // best-fit placement of one request, updates the mirrored shelves
  function automatic placement_t place_rect(logic act, lspbf_pkg::wid_t w, lspbf_pkg::hgt_t h);
    placement_t p;
    int best;
    int unsigned top;
    p = '{default: '0};
    best = -1;
    if (act == lspbf_pkg::ACT_CLEAR) begin
      open_shelves = 0;
      stack_top = '0;
      clears++;
    end else begin
      // fullest shelf that still has room, lowest index on a tie
      for (int k = 0; k < open_shelves; k++) begin
        if (fill_of[k] <= cur_width &&
            lspbf_pkg::wid_t'(cur_width - fill_of[k]) >= w) begin
          if (best < 0 || fill_of[k] > fill_of[best]) begin
            best = k;
          end
        end
      end
      if (best >= 0) begin
        p.pos_x = fill_of[best];
        p.pos_y = base_of[best];
        p.shelf_index = lspbf_pkg::idx_out_t'(best);
        fill_of[best] = fill_of[best] + w;
      end else if (open_shelves >= SHELF_LIMIT) begin
        p.shelves_full = 1'b1;
      end else begin
        // new shelf on top of the stack, even when the rectangle is too wide
        p.pos_y = stack_top;
        p.shelf_index = lspbf_pkg::idx_out_t'(open_shelves);
        p.opened_shelf = 1'b1;
        base_of[open_shelves] = stack_top;
        fill_of[open_shelves] = w;
        open_shelves++;
        top = 32'(stack_top) + 32'(h);
        stack_top = (top > lspbf_pkg::HEIGHT_MAX) ? lspbf_pkg::HEIGHT_MAX :
                    lspbf_pkg::ypos_t'(top);
      end
    end
    p.packed_height = stack_top;
    return p;
  endfunction

  function automatic void push_rect(logic act, lspbf_pkg::wid_t w, lspbf_pkg::hgt_t h);
    rect_req_t r;
    r.is_cfg = 1'b0;
    r.cfg_val = '0;
    r.action = act;
    r.w = w;
    r.h = h;
    request_q.push_back(r);
    queued_rects++;
  endfunction

  function automatic void push_cfg(lspbf_pkg::wid_t v);
    rect_req_t r;
    r.is_cfg = 1'b1;
    r.cfg_val = v;
    r.action = lspbf_pkg::ACT_PLACE;
    r.w = '0;
    r.h = '0;
    request_q.push_back(r);
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // driver: one request at a time, strip width written only when drained
  always @(posedge clk) begin : driver
    logic nxt_valid;
    logic nxt_we;
    rect_req_t r;
    nxt_valid = 1'b0;
    nxt_we = 1'b0;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        placement_q.push_back(place_rect(req_ch.action, req_ch.rect_width, req_ch.rect_height));
        sent++;
      end
      if (req_ch.valid && !req_ch.ready) begin
        nxt_valid = 1'b1;
      end else if (request_q.size() > 0 && request_q[0].is_cfg) begin
        if (!req_ch.valid && !cfg_we && sent == seen) begin
          quiet_cycles++;
        end else begin
          quiet_cycles = 0;
        end
        if (quiet_cycles >= 8) begin
          r = request_q.pop_front();
          nxt_we = 1'b1;
          cfg_data <= r.cfg_val;
          cur_width = r.cfg_val;
          cfg_writes++;
          quiet_cycles = 0;
        end
      end else if (request_q.size() > 0 && (steady || $urandom_range(0, 99) >= 37)) begin
        r = request_q.pop_front();
        nxt_valid = 1'b1;
        req_ch.action <= r.action;
        req_ch.rect_width <= r.w;
        req_ch.rect_height <= r.h;
      end
      req_ch.valid <= nxt_valid;
      cfg_we <= nxt_we;
    end
  end

  // monitor: compare each result with the oldest expected placement
  always @(posedge clk) begin : monitor
    placement_t p;
    if (!rst) begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        seen <= seen + 1;
        if (placement_q.size() == 0) begin
          $display("%0t: result with none expected, actual x %0d y %0d shelf %0d", $time,
                   rsp_ch.pos_x, rsp_ch.pos_y, rsp_ch.shelf_index);
          errors++;
        end else begin
          p = placement_q.pop_front();
          if (p.opened_shelf) opened++;
          if (p.shelves_full) dropped++;
          check_field("pos_x", p.pos_x, rsp_ch.pos_x);
          check_field("pos_y", p.pos_y, rsp_ch.pos_y);
          check_field("shelf_index", p.shelf_index, rsp_ch.shelf_index);
          check_field("opened_shelf", p.opened_shelf, rsp_ch.opened_shelf);
          check_field("packed_height", p.packed_height, rsp_ch.packed_height);
          check_field("shelves_full", p.shelves_full, rsp_ch.shelves_full);
        end
      end
      rsp_ch.ready <= steady || ($urandom_range(0, 99) >= 37);
    end
  end

  initial begin : stimulus
    lspbf_pkg::hgt_t hs[$];
    lspbf_pkg::wid_t width_steps[6];
    lspbf_pkg::wid_t w;
    int unsigned sw;
    int unsigned n;
    int unsigned mode;
    int sets;
    int cfg_step;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.action = lspbf_pkg::ACT_PLACE;
    req_ch.rect_width = '0;
    req_ch.rect_height = '0;
    rsp_ch.ready = 1'b0;

    // directed part at the reset strip width of 1024
    push_rect(lspbf_pkg::ACT_CLEAR, '0, '0);
    push_rect(lspbf_pkg::ACT_PLACE, 16'd0, 16'd0);          // zero-size rectangle, empty shelf
    push_rect(lspbf_pkg::ACT_PLACE, 16'd1024, 16'd65535);   // exact fit on the empty shelf
    push_rect(lspbf_pkg::ACT_PLACE, 16'd1025, 16'd40000);   // too wide, opens anyway
    push_rect(lspbf_pkg::ACT_PLACE, 16'd65535, 16'd30000);  // widest, too wide
    push_rect(lspbf_pkg::ACT_PLACE, 16'd0, 16'd20000);      // zero width on a full shelf
    push_rect(lspbf_pkg::ACT_PLACE, 16'd600, 16'd20000);
    push_rect(lspbf_pkg::ACT_PLACE, 16'd600, 16'd15000);
    push_rect(lspbf_pkg::ACT_PLACE, 16'd300, 16'd100);      // equal fill, lower shelf wins
    push_rect(lspbf_pkg::ACT_PLACE, 16'd100, 16'd100);      // fuller shelf wins
    push_rect(lspbf_pkg::ACT_PLACE, 16'd124, 16'd100);
    push_rect(lspbf_pkg::ACT_PLACE, 16'd24, 16'd5);         // fills a shelf exactly
    push_rect(lspbf_pkg::ACT_PLACE, 16'd1, 16'd1);
    push_rect(lspbf_pkg::ACT_CLEAR, 16'hFFFF, 16'hFFFF);
    push_rect(lspbf_pkg::ACT_PLACE, 16'hAAAA, 16'h5555);
    push_rect(lspbf_pkg::ACT_PLACE, 16'h5555, 16'hAAAA);
    push_rect(lspbf_pkg::ACT_PLACE, 16'd3, 16'd7);

    // random sets of rectangles, most sorted by height, strip width changed between sets
    width_steps = '{16'd1, 16'd65535, 16'd7, 16'd40, 16'd300, 16'd1024};
    sw = 32'(lspbf_pkg::STRIP_WIDTH_RESET);
    sets = 0;
    cfg_step = 0;
    while (queued_rects < RAND_RECTS + 17) begin
      if (sets % 7 == 6) begin
        sw = (cfg_step < 6) ? 32'(width_steps[cfg_step]) : $urandom_range(1, 65535);
        cfg_step = (cfg_step + 1) % 8;
        push_cfg(lspbf_pkg::wid_t'(sw));
      end
      sets++;
      mode = $urandom_range(0, 9);
      n = (mode < 3) ? $urandom_range(34, 48) : $urandom_range(1, 24);
      hs.delete();
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: hs.push_back(lspbf_pkg::hgt_t'($urandom_range(0, 65535)));
          3, 4:    hs.push_back(lspbf_pkg::hgt_t'($urandom_range(0, 20)));
          default: hs.push_back(lspbf_pkg::hgt_t'($urandom_range(0, 300)));
        endcase
      end
      // noise sets keep their random order and get clears mixed in
      if (mode != 9) hs.rsort();
      if ($urandom_range(0, 4) != 0) begin
        push_rect(lspbf_pkg::ACT_CLEAR, lspbf_pkg::wid_t'($urandom_range(0, 65535)),
                  lspbf_pkg::hgt_t'($urandom_range(0, 65535)));
      end
      foreach (hs[i]) begin
        if (mode == 9 && $urandom_range(0, 9) == 0) begin
          push_rect(lspbf_pkg::ACT_CLEAR, lspbf_pkg::wid_t'($urandom_range(0, 65535)),
                    lspbf_pkg::hgt_t'($urandom_range(0, 65535)));
        end
        case ($urandom_range(0, 11))
          0: w = '0;
          1: w = lspbf_pkg::wid_t'(sw);
          2: w = lspbf_pkg::wid_t'((sw < 65535) ? $urandom_range(sw + 1, 65535) : sw);
          3: w = lspbf_pkg::wid_t'($urandom_range(0, 65535));
          default: begin
            if (mode < 3) begin
              w = lspbf_pkg::wid_t'($urandom_range(sw / 2 + 1, sw));
            end else begin
              w = lspbf_pkg::wid_t'($urandom_range(1, (sw > 1) ? sw / 2 : 1));
            end
          end
        endcase
        push_rect(lspbf_pkg::ACT_PLACE, w, hs[i]);
      end
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (request_q.size() != 0 || req_ch.valid || cfg_we || placement_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);

    $display("checked %0d results: %0d clears, %0d shelves opened, %0d rectangles dropped",
             seen, clears, opened, dropped);
    $display("strip width rewritten %0d times over %0d rectangle sets", cfg_writes, sets);
    if (errors == 0 && seen == sent) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
